>>> rtl/rps_pkg.sv
package rps_pkg;

  // Fixed field widths of the request and result items.
  localparam int unsigned CfgW   = 7;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned ReqW   = 2;
  localparam int unsigned BinIdxW = 7;
  localparam int unsigned MeanW  = 32;
  localparam int unsigned CntW   = 13;
  localparam int unsigned LenW   = 7;
  localparam int unsigned SumW   = 44;

  // Request codes.
  localparam logic [ReqW-1:0] REQ_SAMPLE = 2'd0;
  localparam logic [ReqW-1:0] REQ_READ   = 2'd1;
  localparam logic [ReqW-1:0] REQ_FRAME  = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_X_SIZE   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_Y_SIZE   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_CENTERED = 2'd2;

  // Handshake status of an iterative arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

>>> rtl/rps_if.sv
interface rps_req_if #(
  parameter int unsigned SAMPLE_BITS = 16
);
  import rps_pkg::*;
  logic                          valid;
  logic                          ready;
  logic [ReqW-1:0]               req_type;
  logic signed [SAMPLE_BITS-1:0] real_part;
  logic signed [SAMPLE_BITS-1:0] imag_part;
  logic [BinIdxW-1:0]            bin_index;

  modport source (output valid, req_type, real_part, imag_part, bin_index, input ready);
  modport sink (input valid, req_type, real_part, imag_part, bin_index, output ready);
endinterface

interface rps_res_if;
  import rps_pkg::*;
  logic             valid;
  logic             ready;
  logic [MeanW-1:0] mean_power;
  logic [CntW-1:0]  bin_count;
  logic [LenW-1:0]  spectrum_length;
  logic             bin_valid;

  modport source (output valid, mean_power, bin_count, spectrum_length, bin_valid, input ready);
  modport sink (input valid, mean_power, bin_count, spectrum_length, bin_valid, output ready);
endinterface

>>> rtl/rps_isqrt.sv
module rps_isqrt import rps_pkg::*; #(
  parameter int unsigned N_W = 15
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [N_W-1:0]           n_i,
  output unit_sts_t                sts_o,
  output logic [(N_W+1)/2:0]       root_o
);

  localparam int unsigned H  = (N_W + 1) / 2;
  localparam int unsigned BW = 2 * H;

  logic [BW-1:0] rem_q, rem_d, root_q, root_d, bit_q, bit_d;
  logic [BW:0]   trial;
  logic          done_q, done_d;

  // One result bit per cycle: trial subtract of root plus the current bit.
  always_comb begin
    rem_d  = rem_q;
    root_d = root_q;
    bit_d  = bit_q;
    done_d = 1'b0;
    trial  = {1'b0, root_q} + {1'b0, bit_q};
    if (start_i) begin
      rem_d  = BW'(n_i);
      root_d = '0;
      bit_d  = BW'(1) << (BW - 2);
    end else if (bit_q != '0) begin
      if ({1'b0, rem_q} >= trial) begin
        rem_d  = rem_q - trial[BW-1:0];
        root_d = (root_q >> 1) + bit_q;
      end else begin
        root_d = root_q >> 1;
      end
      bit_d  = bit_q >> 2;
      done_d = (bit_q[1:0] != 2'b00);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q  <= '0;
      done_q <= 1'b0;
    end else begin
      bit_q  <= bit_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  // Round to nearest: step up when the remainder exceeds the root.
  assign root_o     = (H+1)'(root_q) + (H+1)'(rem_q > root_q);
  assign sts_o.busy = (bit_q != '0);
  assign sts_o.done = done_q;

endmodule

>>> rtl/rps_div.sv
module rps_div import rps_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [SumW-1:0] dividend_i,
  input  logic [CntW-1:0] divisor_i,
  output unit_sts_t       sts_o,
  output logic [SumW-1:0] quot_o
);

  localparam int unsigned StepW = $clog2(SumW + 1);

  logic [SumW-1:0]  quot_q, quot_d;
  logic [CntW-1:0]  dvs_q, dvs_d;
  logic [CntW:0]    rem_q, rem_d, shifted;
  logic [StepW-1:0] step_q, step_d;
  logic             done_q, done_d;

  // Restoring division, one quotient bit per cycle from the top down.
  always_comb begin
    quot_d  = quot_q;
    dvs_d   = dvs_q;
    rem_d   = rem_q;
    step_d  = step_q;
    done_d  = 1'b0;
    shifted = {rem_q[CntW-1:0], quot_q[SumW-1]};
    if (start_i) begin
      quot_d = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
      step_d = StepW'(SumW);
    end else if (step_q != '0) begin
      if (shifted >= {1'b0, dvs_q}) begin
        rem_d  = shifted - {1'b0, dvs_q};
        quot_d = {quot_q[SumW-2:0], 1'b1};
      end else begin
        rem_d  = shifted;
        quot_d = {quot_q[SumW-2:0], 1'b0};
      end
      step_d = step_q - 1'b1;
      done_d = (step_q == StepW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      done_q <= 1'b0;
    end else begin
      step_q <= step_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    dvs_q  <= dvs_d;
    rem_q  <= rem_d;
  end

  assign quot_o     = quot_q;
  assign sts_o.busy = (step_q != '0);
  assign sts_o.done = done_q;

endmodule

>>> rtl/radial_power_spectrum.sv
// Radially averaged power spectrum. Coefficient items arrive in row-major order; each adds
// re*re+im*im into the bin of its rounded distance from the origin (or the grid centre when
// centred), a read item returns a bin's truncated mean, count and the spectrum length, and a
// frame item clears all bins and the grid position at once. One item is worked on at a time
// and ready is low meanwhile. The shared square-root unit runs twice per coefficient and once
// per read, one bit a cycle, and the mean comes from a one-bit-a-cycle divider. Bins live in a
// single-port memory with one valid flag per bin, so no clearing pass is needed after reset.
module radial_power_spectrum import rps_pkg::*; #(
  parameter int unsigned MAX_SIDE    = 64,
  parameter int unsigned BIN_DEPTH   = 128,
  parameter int unsigned SAMPLE_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_wdata_i,
  rps_req_if.sink            req_i,
  rps_res_if.source          res_o
);

  localparam int unsigned SideW = $clog2(MAX_SIDE + 1);
  localparam int unsigned PosW  = $clog2(MAX_SIDE);
  localparam int unsigned RnW   = 2 * SideW + 1;
  localparam int unsigned RootW = (RnW + 1) / 2 + 1;
  localparam int unsigned BinAW = $clog2(BIN_DEPTH);
  localparam int unsigned BLenW = $clog2(BIN_DEPTH + 1);
  localparam int unsigned ProdW = 2 * SAMPLE_BITS;
  localparam int unsigned PowW  = ProdW + 1;
  localparam int unsigned AccW  = ((PowW > SumW) ? PowW : SumW) + 1;
  localparam int unsigned EntW  = CntW + SumW;

  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_LEN  = 8'b0000_0010,
    ST_RAD  = 8'b0000_0100,
    ST_RD   = 8'b0000_1000,
    ST_UPD  = 8'b0001_0000,
    ST_CHK  = 8'b0010_0000,
    ST_DIV  = 8'b0100_0000,
    ST_OUT  = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [CfgW-1:0] x_size_q, y_size_q;
  logic            cen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_size_q <= CfgW'(64);
      y_size_q <= CfgW'(64);
      cen_q    <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_X_SIZE:   x_size_q <= cfg_wdata_i;
        CFG_Y_SIZE:   y_size_q <= cfg_wdata_i;
        CFG_CENTERED: cen_q    <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Grid sides saturated to 1..MAX_SIDE.
  logic [SideW-1:0] xs, ys;
  always_comb begin
    if (x_size_q == '0) xs = SideW'(1);
    else if (int'(x_size_q) > MAX_SIDE) xs = SideW'(MAX_SIDE);
    else xs = SideW'(x_size_q);
    if (y_size_q == '0) ys = SideW'(1);
    else if (int'(y_size_q) > MAX_SIDE) ys = SideW'(MAX_SIDE);
    else ys = SideW'(y_size_q);
  end

  // Square-root operands: diagonal for the spectrum length, distance for the radius.
  logic [PosW-1:0]  row_q, row_d, col_q, col_d;
  logic [2*SideW-1:0] xsq, ysq, dxsq, dysq;
  logic [SideW:0]   dx, dy;
  logic [SideW-1:0] adx, ady;
  logic [RnW-1:0]   n_len, n_rad, sq_n;

  always_comb begin
    xsq   = xs * xs;
    ysq   = ys * ys;
    n_len = cen_q ? (RnW'(xsq >> 2) + RnW'(ysq >> 2)) : (RnW'(xsq) + RnW'(ysq));
    dx    = (SideW+1)'(row_q);
    dy    = (SideW+1)'(col_q);
    if (cen_q) begin
      dx = dx - (SideW+1)'(xs >> 1);
      dy = dy - (SideW+1)'(ys >> 1);
    end
    adx   = dx[SideW] ? SideW'(-dx) : dx[SideW-1:0];
    ady   = dy[SideW] ? SideW'(-dy) : dy[SideW-1:0];
    dxsq  = adx * adx;
    dysq  = ady * ady;
    n_rad = RnW'(dxsq) + RnW'(dysq);
  end

  logic             sq_start;
  unit_sts_t        sq_sts;
  logic [RootW-1:0] sq_root;

  assign sq_n = (state_q == ST_LEN) ? n_rad : n_len;

  rps_isqrt #(.N_W(RnW)) u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .n_i     (sq_n),
    .sts_o   (sq_sts),
    .root_o  (sq_root)
  );

  logic            dv_start;
  unit_sts_t       dv_sts;
  logic [SumW-1:0] dv_quot;
  logic [CntW-1:0] cur_cnt;
  logic [SumW-1:0] cur_sum;

  rps_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (dv_start),
    .dividend_i (cur_sum),
    .divisor_i  (cur_cnt),
    .sts_o      (dv_sts),
    .quot_o     (dv_quot)
  );

  // Item registers.
  logic [ReqW-1:0]  req_q;
  logic [BinIdxW-1:0] bidx_q;
  logic [ProdW-1:0] re2_q, im2_q;
  logic signed [ProdW-1:0] re2, im2;
  logic [BLenW-1:0] len_q, len_d, len_sel;
  logic [BinAW-1:0] addr_q, addr_d;
  logic             inr_q, inr_d;

  assign re2 = req_i.real_part * req_i.real_part;
  assign im2 = req_i.imag_part * req_i.imag_part;

  // Spectrum length from the root, kept within 1..BIN_DEPTH.
  always_comb begin
    if (sq_root == '0) len_sel = BLenW'(1);
    else if (int'(sq_root) > BIN_DEPTH) len_sel = BLenW'(BIN_DEPTH);
    else len_sel = BLenW'(sq_root);
  end

  // Bin memory with one valid flag per bin.
  logic [EntW-1:0]      bin_mem [BIN_DEPTH];
  logic [BIN_DEPTH-1:0] bv_q, bv_d;
  logic [EntW-1:0]      rd_q, wr_data;
  logic                 rd_ok_q;
  logic                 wr_en;

  always_ff @(posedge clk_i) begin
    if (state_q == ST_RD) rd_q <= bin_mem[addr_q];
    if (wr_en) bin_mem[addr_q] <= wr_data;
  end

  assign cur_cnt = rd_ok_q ? rd_q[EntW-1:SumW] : '0;
  assign cur_sum = rd_ok_q ? rd_q[SumW-1:0] : '0;

  // Saturating accumulate of the new power.
  logic [AccW-1:0] acc;
  logic [SumW-1:0] new_sum;
  always_comb begin
    acc     = AccW'(cur_sum) + AccW'(re2_q) + AccW'(im2_q);
    new_sum = (acc > AccW'({SumW{1'b1}})) ? {SumW{1'b1}} : acc[SumW-1:0];
    wr_data = {cur_cnt + 1'b1, new_sum};
  end

  // Result holding register.
  logic             rv_q, rv_d;
  logic [MeanW-1:0] mean_q, mean_d, rmean_q, rmean_d;
  logic [CntW-1:0]  rcnt_q, rcnt_d, ocnt_q, ocnt_d;
  logic [LenW-1:0]  rlen_q, rlen_d;
  logic             rbv_q, rbv_d;

  // Sequencer.
  always_comb begin
    state_d  = state_q;
    len_d    = len_q;
    addr_d   = addr_q;
    inr_d    = inr_q;
    row_d    = row_q;
    col_d    = col_q;
    bv_d     = bv_q;
    rv_d     = rv_q;
    mean_d   = mean_q;
    ocnt_d   = ocnt_q;
    rmean_d  = rmean_q;
    rcnt_d   = rcnt_q;
    rlen_d   = rlen_q;
    rbv_d    = rbv_q;
    sq_start = 1'b0;
    dv_start = 1'b0;
    wr_en    = 1'b0;
    if (res_o.ready) rv_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          if (req_i.req_type == REQ_SAMPLE || req_i.req_type == REQ_READ) begin
            sq_start = 1'b1;
            state_d  = ST_LEN;
          end else if (req_i.req_type == REQ_FRAME) begin
            bv_d  = '0;
            row_d = '0;
            col_d = '0;
          end
        end
      end
      ST_LEN: begin
        if (sq_sts.done) begin
          len_d = len_sel;
          if (req_q == REQ_SAMPLE) begin
            sq_start = 1'b1;
            state_d  = ST_RAD;
          end else begin
            inr_d   = (int'(bidx_q) < int'(len_sel));
            addr_d  = BinAW'(bidx_q);
            state_d = ST_RD;
          end
        end
      end
      ST_RAD: begin
        if (sq_sts.done) begin
          if (int'(sq_root) >= int'(len_q)) addr_d = BinAW'(len_q - 1'b1);
          else addr_d = BinAW'(sq_root);
          state_d = ST_RD;
        end
      end
      ST_RD: begin
        state_d = (req_q == REQ_SAMPLE) ? ST_UPD : ST_CHK;
      end
      ST_UPD: begin
        if (cur_cnt != {CntW{1'b1}}) begin
          wr_en        = 1'b1;
          bv_d[addr_q] = 1'b1;
        end
        if ((SideW'(col_q) + 1'b1) >= ys) begin
          col_d = '0;
          row_d = ((SideW'(row_q) + 1'b1) >= xs) ? '0 : row_q + 1'b1;
        end else begin
          col_d = col_q + 1'b1;
        end
        state_d = ST_IDLE;
      end
      ST_CHK: begin
        ocnt_d = inr_q ? cur_cnt : '0;
        mean_d = '0;
        if (inr_q && cur_cnt != '0) begin
          dv_start = 1'b1;
          state_d  = ST_DIV;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_DIV: begin
        if (dv_sts.done) begin
          mean_d  = (dv_quot[SumW-1:MeanW] != '0) ? {MeanW{1'b1}} : dv_quot[MeanW-1:0];
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!rv_q || res_o.ready) begin
          rv_d    = 1'b1;
          rmean_d = mean_q;
          rcnt_d  = ocnt_q;
          rlen_d  = LenW'(len_q);
          rbv_d   = inr_q;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= '0;
      col_q   <= '0;
      bv_q    <= '0;
      rv_q    <= 1'b0;
      rd_ok_q <= 1'b0;
      req_q   <= REQ_SAMPLE;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      bv_q    <= bv_d;
      rv_q    <= rv_d;
      if (state_q == ST_RD) rd_ok_q <= bv_q[addr_q];
      if (state_q == ST_IDLE && req_i.valid) req_q <= req_i.req_type;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q   <= len_d;
    addr_q  <= addr_d;
    inr_q   <= inr_d;
    mean_q  <= mean_d;
    ocnt_q  <= ocnt_d;
    rmean_q <= rmean_d;
    rcnt_q  <= rcnt_d;
    rlen_q  <= rlen_d;
    rbv_q   <= rbv_d;
    if (state_q == ST_IDLE && req_i.valid) begin
      bidx_q <= req_i.bin_index;
      re2_q  <= ProdW'(re2);
      im2_q  <= ProdW'(im2);
    end
  end

  // Port outputs.
  assign req_i.ready           = (state_q == ST_IDLE);
  assign res_o.valid           = rv_q;
  assign res_o.mean_power      = rmean_q;
  assign res_o.bin_count       = rcnt_q;
  assign res_o.spectrum_length = rlen_q;
  assign res_o.bin_valid       = rbv_q;

`ifndef NO_ASSERTIONS
  // The arithmetic units are never left running while a new item may enter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> !sq_sts.busy && !dv_sts.busy)
    else $error("arithmetic unit busy while idle");

  // A bin outside the spectrum reports no power and no entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.bin_valid |-> res_o.mean_power == '0 && res_o.bin_count == '0)
    else $error("out-of-range bin carries data");

  // An empty bin has a zero mean.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.bin_count == '0 |-> res_o.mean_power == '0)
    else $error("empty bin with non-zero mean");
`endif

endmodule
